>>> rtl/scf_pkg.sv
// shared types, command codes, register indexes and sine table math
// for the stereo chorus / flanger; used by every module of the block but scf_ram
`default_nettype none
package scf_pkg;

  typedef struct packed {
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
  } out_word_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MIX_WET      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_DEPTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_MODE  = 3'd5;

  localparam logic [15:0] RST_MIX_WET      = 16'd32768;
  localparam logic [15:0] RST_MOD_DEPTH    = 16'd32768;
  localparam logic [31:0] RST_PHASE_STEP   = 32'd894785;
  localparam logic [31:0] RST_RIGHT_OFFSET = 32'd0;
  localparam logic [15:0] RST_FEEDBACK     = 16'd32768;
  localparam logic        RST_EFFECT_MODE  = 1'b0;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LATCH,
    OP_WRITE,
    OP_LFO,
    OP_DELAY,
    OP_MOD,
    OP_ADDR,
    OP_RD0,
    OP_RD1,
    OP_INTERP,
    OP_SUM,
    OP_FB,
    OP_MIX,
    OP_ADVANCE
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_LFO,
    ST_DELAY,
    ST_MOD,
    ST_ADDR,
    ST_RD0,
    ST_RD1,
    ST_INTERP,
    ST_SUM,
    ST_FB,
    ST_MIX,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t  op;
    logic ch;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic mod_done;
  } status_t;

  // quarter wave polynomial, x in q14 (0..16384), result q15
  function automatic longint quarter_sine(longint x);
    longint x2;
    longint p;
    x2 = (x * x) / 16384;
    p  = 2611;
    p  = -21167 + (p * x2) / 16384;
    p  = 51472 + (p * x2) / 16384;
    p  = (p * x) / 16384;
    if (p > 32767) p = 32767;
    return p;
  endfunction

  // one table entry from a 16 bit angle (full cycle = 65536)
  function automatic logic signed [15:0] sine_entry(int a);
    int     t;
    longint s;
    t = a & 32767;
    if (t > 16384) t = 32768 - t;
    s = quarter_sine(longint'(t));
    if ((a & 32768) != 0) s = -s;
    return 16'(s);
  endfunction

endpackage
`default_nettype wire

>>> rtl/scf_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`default_nettype none
module scf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/scf_ctrl.sv
// sequencer for the chorus / flanger: runs the clear pass, then each word
// through both channels step by step; uses scf_pkg
`default_nettype none
module scf_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output scf_pkg::cmd_t       cmd,
  input  wire scf_pkg::status_t status
);

  scf_pkg::state_t state, state_next;
  logic ch, ch_next;
  logic out_valid_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= scf_pkg::ST_CLEAR;
      ch        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ch        <= ch_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    ch_next    = ch;
    unique case (state)
      scf_pkg::ST_CLEAR: begin
        if (status.clear_last) state_next = scf_pkg::ST_IDLE;
      end
      scf_pkg::ST_IDLE: begin
        ch_next = 1'b0;
        if (in_valid) state_next = scf_pkg::ST_WRITE;
      end
      scf_pkg::ST_WRITE:  state_next = scf_pkg::ST_LFO;
      scf_pkg::ST_LFO:    state_next = scf_pkg::ST_DELAY;
      scf_pkg::ST_DELAY:  state_next = scf_pkg::ST_MOD;
      scf_pkg::ST_MOD: begin
        if (status.mod_done) state_next = scf_pkg::ST_ADDR;
      end
      scf_pkg::ST_ADDR:   state_next = scf_pkg::ST_RD0;
      scf_pkg::ST_RD0:    state_next = scf_pkg::ST_RD1;
      scf_pkg::ST_RD1:    state_next = scf_pkg::ST_INTERP;
      scf_pkg::ST_INTERP: state_next = scf_pkg::ST_SUM;
      scf_pkg::ST_SUM:    state_next = scf_pkg::ST_FB;
      scf_pkg::ST_FB:     state_next = scf_pkg::ST_MIX;
      scf_pkg::ST_MIX: begin
        if (ch) begin
          state_next = scf_pkg::ST_DONE;
        end else begin
          ch_next    = 1'b1;
          state_next = scf_pkg::ST_WRITE;
        end
      end
      scf_pkg::ST_DONE: begin
        if (out_free) state_next = scf_pkg::ST_IDLE;
      end
      default: state_next = scf_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd.op         = scf_pkg::OP_NONE;
    cmd.ch         = ch;
    in_ready       = 1'b0;
    out_valid_next = out_ready ? 1'b0 : out_valid;
    unique case (state)
      scf_pkg::ST_CLEAR:  cmd.op = scf_pkg::OP_CLEAR;
      scf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = scf_pkg::OP_LATCH;
      end
      scf_pkg::ST_WRITE:  cmd.op = scf_pkg::OP_WRITE;
      scf_pkg::ST_LFO:    cmd.op = scf_pkg::OP_LFO;
      scf_pkg::ST_DELAY:  cmd.op = scf_pkg::OP_DELAY;
      scf_pkg::ST_MOD:    cmd.op = scf_pkg::OP_MOD;
      scf_pkg::ST_ADDR:   cmd.op = scf_pkg::OP_ADDR;
      scf_pkg::ST_RD0:    cmd.op = scf_pkg::OP_RD0;
      scf_pkg::ST_RD1:    cmd.op = scf_pkg::OP_RD1;
      scf_pkg::ST_INTERP: cmd.op = scf_pkg::OP_INTERP;
      scf_pkg::ST_SUM:    cmd.op = scf_pkg::OP_SUM;
      scf_pkg::ST_FB:     cmd.op = scf_pkg::OP_FB;
      scf_pkg::ST_MIX:    cmd.op = scf_pkg::OP_MIX;
      scf_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.op         = scf_pkg::OP_ADVANCE;
          out_valid_next = 1'b1;
        end
      end
      default: cmd.op = scf_pkg::OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/scf_datapath.sv
// datapath: config registers, lfo, delay math, delay rings, interpolation,
// feedback and mix; driven by scf_ctrl commands; uses scf_pkg and scf_ram
`default_nettype none
module scf_datapath #(
  parameter int DELAY_DEPTH     = 4096,
  parameter int SAMPLE_RATE     = 48000,
  parameter int SINE_TABLE_SIZE = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire scf_pkg::cmd_t                     cmd,
  output scf_pkg::status_t                       status,
  input  wire scf_pkg::in_word_t                 in_data,
  output scf_pkg::out_word_t                     out_data,
  input  wire logic                              cfg_we,
  input  wire logic [scf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [scf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW      = $clog2(DELAY_DEPTH);
  localparam int TW      = $clog2(SINE_TABLE_SIZE);
  localparam int SBW     = $clog2(SINE_TABLE_SIZE + 1);
  localparam int LO_CH   = (SAMPLE_RATE * 256) / 200;
  localparam int SPAN_CH = (SAMPLE_RATE * 256) / 40;
  localparam int LO_FL   = (SAMPLE_RATE * 256) / 1000;
  localparam int SPAN_FL = (SAMPLE_RATE * 256) / 250;
  localparam int SW      = $clog2(SPAN_CH + 1);
  localparam int DW      = $clog2(LO_CH + SPAN_CH + 1);
  localparam int QW      = AW + 8;
  localparam int RQW     = AW + 9;
  localparam int CW      = (DW > RQW) ? DW : RQW;
  localparam int RINGQ   = DELAY_DEPTH * 256;

  // configuration
  logic [15:0] mix_wet, mod_depth, feedback_gain;
  logic [31:0] phase_step, right_phase_offset;
  logic        effect_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_wet            <= scf_pkg::RST_MIX_WET;
      mod_depth          <= scf_pkg::RST_MOD_DEPTH;
      phase_step         <= scf_pkg::RST_PHASE_STEP;
      right_phase_offset <= scf_pkg::RST_RIGHT_OFFSET;
      feedback_gain      <= scf_pkg::RST_FEEDBACK;
      effect_mode        <= scf_pkg::RST_EFFECT_MODE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scf_pkg::CFG_MIX_WET:      mix_wet            <= cfg_data[15:0];
        scf_pkg::CFG_MOD_DEPTH:    mod_depth          <= cfg_data[15:0];
        scf_pkg::CFG_PHASE_STEP:   phase_step         <= cfg_data;
        scf_pkg::CFG_RIGHT_OFFSET: right_phase_offset <= cfg_data;
        scf_pkg::CFG_FEEDBACK:     feedback_gain      <= cfg_data[15:0];
        scf_pkg::CFG_EFFECT_MODE:  effect_mode        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sine table, built at elaboration
  logic signed [15:0] sine_rom [SINE_TABLE_SIZE];
  for (genvar k = 0; k < SINE_TABLE_SIZE; k++) begin : g_sine
    localparam int A = (k * 65536) / SINE_TABLE_SIZE;
    assign sine_rom[k] = scf_pkg::sine_entry(A);
  end

  // state and working registers
  logic [AW-1:0]       wp, clr_addr, i0, i1;
  logic [31:0]         lfo_phase;
  logic signed [15:0]  fb_l, fb_r, in_l, in_r, res_l, res_r, lfo, r0, y;
  logic [TW-1:0]       sidx;
  logic [CW-1:0]       delay;
  logic [7:0]          f;
  logic signed [25:0]  p0, p1;
  logic signed [33:0]  m0;
  logic signed [32:0]  m1;

  // ring rams
  logic                we_l, we_r;
  logic [AW-1:0]       waddr, raddr;
  logic [15:0]         wdata, rdata_l, rdata_r;
  logic signed [15:0]  rdata;

  scf_ram #(.WIDTH(16), .DEPTH(DELAY_DEPTH)) u_ring_l (
    .clk(clk), .we(we_l), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata_l)
  );

  scf_ram #(.WIDTH(16), .DEPTH(DELAY_DEPTH)) u_ring_r (
    .clk(clk), .we(we_r), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata_r)
  );

  // per channel selects
  logic signed [15:0] cur_in, cur_fb;
  assign cur_in = cmd.ch ? in_r : in_l;
  assign cur_fb = cmd.ch ? fb_r : fb_l;
  assign rdata  = $signed(cmd.ch ? rdata_r : rdata_l);

  // ring write value, saturated
  logic signed [16:0] wsum;
  logic signed [15:0] wsat;
  always_comb begin
    wsum = 17'(cur_in) + 17'(cur_fb);
    if (wsum > 17'sd32767)       wsat = 16'sh7fff;
    else if (wsum < -17'sd32768) wsat = 16'sh8000;
    else                         wsat = wsum[15:0];
  end

  always_comb begin
    we_l  = 1'b0;
    we_r  = 1'b0;
    waddr = wp;
    wdata = wsat;
    raddr = (cmd.op == scf_pkg::OP_RD1) ? i1 : i0;
    if (cmd.op == scf_pkg::OP_CLEAR) begin
      we_l  = 1'b1;
      we_r  = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else if (cmd.op == scf_pkg::OP_WRITE) begin
      we_l = !cmd.ch;
      we_r = cmd.ch;
    end
  end

  // table index from phase
  logic [31:0]        ph;
  logic [32+SBW-1:0]  sprod;
  assign ph    = lfo_phase + (cmd.ch ? right_phase_offset : 32'd0);
  assign sprod = {{SBW{1'b0}}, ph} * (32 + SBW)'(SINE_TABLE_SIZE);

  // lfo scaled by depth, truncated toward zero
  logic signed [32:0] lprod, lprod_adj;
  assign lprod     = 33'(sine_rom[sidx]) * 33'($signed({1'b0, mod_depth}));
  assign lprod_adj = lprod + (lprod[32] ? 33'sd65535 : 33'sd0);

  // delay in q.8 samples
  logic [15:0]       u;
  logic [SW-1:0]     span;
  logic [DW-1:0]     lo, delay_n;
  logic [16+SW-1:0]  dprod;
  assign u       = lfo ^ 16'h8000;
  assign span    = effect_mode ? SW'(SPAN_FL) : SW'(SPAN_CH);
  assign lo      = effect_mode ? DW'(LO_FL) : DW'(LO_CH);
  assign dprod   = {{SW{1'b0}}, u} * {16'd0, span};
  assign delay_n = lo + DW'(dprod[16 +: SW]);

  assign status.mod_done = delay < CW'(RINGQ);

  // read position
  logic [RQW-1:0] rsum, rd;
  logic [AW-1:0]  i0_n;
  always_comb begin
    rsum = {1'b0, wp, 8'd0} + RQW'(RINGQ) - {1'b0, delay[QW-1:0]};
    rd   = (rsum >= RQW'(RINGQ)) ? rsum - RQW'(RINGQ) : rsum;
    i0_n = rd[QW-1:8];
  end

  // interpolation sum, truncated toward zero
  logic signed [26:0] isum, isum_adj;
  logic [8:0]         wf;
  assign wf       = 9'd256 - {1'b0, f};
  assign isum     = 27'(p0) + 27'(p1);
  assign isum_adj = isum + (isum[26] ? 27'sd255 : 27'sd0);

  // feedback and mix products
  logic signed [32:0] fprod, fprod_adj;
  logic [16:0]        dry;
  assign fprod     = 33'(y) * 33'($signed({1'b0, feedback_gain}));
  assign fprod_adj = fprod + (fprod[32] ? 33'sd65535 : 33'sd0);
  assign dry       = 17'h10000 - {1'b0, mix_wet};

  logic signed [34:0] msum, msum_adj, mq;
  logic signed [15:0] msat;
  always_comb begin
    msum     = 35'(m0) + 35'(m1);
    msum_adj = msum + (msum[34] ? 35'sd65535 : 35'sd0);
    mq       = msum_adj >>> 16;
    if (mq > 35'sd32767)       msat = 16'sh7fff;
    else if (mq < -35'sd32768) msat = 16'sh8000;
    else                       msat = mq[15:0];
  end

  assign status.clear_last = clr_addr == AW'(DELAY_DEPTH - 1);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      clr_addr  <= '0;
      lfo_phase <= '0;
      fb_l      <= '0;
      fb_r      <= '0;
    end else begin
      case (cmd.op)
        scf_pkg::OP_CLEAR: clr_addr <= clr_addr + 1'b1;
        scf_pkg::OP_FB: begin
          if (cmd.ch) fb_r <= fprod_adj[31:16];
          else        fb_l <= fprod_adj[31:16];
        end
        scf_pkg::OP_ADVANCE: begin
          lfo_phase <= lfo_phase + phase_step;
          wp        <= (wp == AW'(DELAY_DEPTH - 1)) ? '0 : wp + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      scf_pkg::OP_LATCH: begin
        in_l <= in_data.left_in;
        in_r <= in_data.right_in;
      end
      scf_pkg::OP_WRITE:  sidx  <= sprod[32 +: TW];
      scf_pkg::OP_LFO:    lfo   <= lprod_adj[31:16];
      scf_pkg::OP_DELAY:  delay <= CW'(delay_n);
      scf_pkg::OP_MOD: begin
        if (!status.mod_done) delay <= delay - CW'(RINGQ);
      end
      scf_pkg::OP_ADDR: begin
        i0 <= i0_n;
        i1 <= (i0_n == AW'(DELAY_DEPTH - 1)) ? '0 : i0_n + 1'b1;
        f  <= rd[7:0];
      end
      scf_pkg::OP_RD1:    r0 <= rdata;
      scf_pkg::OP_INTERP: begin
        p0 <= 26'(r0) * 26'($signed({1'b0, wf}));
        p1 <= 26'(rdata) * 26'($signed({2'b0, f}));
      end
      scf_pkg::OP_SUM:    y <= isum_adj[23:8];
      scf_pkg::OP_FB: begin
        m0 <= 34'(cur_in) * 34'($signed({1'b0, dry}));
        m1 <= 33'(y) * 33'($signed({1'b0, mix_wet}));
      end
      scf_pkg::OP_MIX: begin
        if (cmd.ch) res_r <= msat;
        else        res_l <= msat;
      end
      scf_pkg::OP_ADVANCE: begin
        out_data.left_out  <= res_l;
        out_data.right_out <= res_r;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/stereo_chorus_flanger_top.sv
// top level of the stereo chorus / flanger with lfo modulated delay
// instantiates scf_ctrl and scf_datapath; uses scf_pkg
`default_nettype none
//
//  channel  handshake              payload                     role
//  in       in_valid / in_ready    in_data (left_in,right_in)  one stereo word in
//  out      out_valid / out_ready  out_data (left,right out)   one mixed word out
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data         register write
//
//  each channel of a word runs in turn through the shared sequencer
//  (ring write, lfo, delay, ring reads, interpolation, feedback, mix),
//  with one more modulo step per wrap of the delay into the ring
//  after reset a clearing pass zeroes every address of both rings;
//  in_ready stays low during it, config writes are taken as always
//  a finished word waits in the output register; the next word is
//  accepted while it waits, and only the final hand-off stalls on out_ready
module stereo_chorus_flanger_top #(
  parameter int DELAY_DEPTH     = 4096,
  parameter int SAMPLE_RATE     = 48000,
  parameter int SINE_TABLE_SIZE = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire scf_pkg::in_word_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output scf_pkg::out_word_t                  out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [scf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [scf_pkg::CFG_DATA_W-1:0] cfg_data
);

  scf_pkg::cmd_t    cmd;
  scf_pkg::status_t status;

  // config registers take a write in any cycle out of reset
  assign cfg_ready = 1'b1;

  // sequencer: clear pass, per channel steps, output hand-off
  scf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // arithmetic, rings and registers
  scf_datapath #(
    .DELAY_DEPTH     (DELAY_DEPTH),
    .SAMPLE_RATE     (SAMPLE_RATE),
    .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
`default_nettype wire

>>> test/stereo_chorus_flanger_top_test.sv
// self-checking testbench for the stereo chorus / flanger top level
// predicts each mixed word from its own model of rings, lfo and registers; uses scf_pkg
`timescale 1ns / 1ps

class sample_scoreboard;
  localparam int RING_LEN = 4096;
  localparam int RATE     = 48000;
  localparam int SINE_LEN = 1024;

  logic signed [15:0] left_ring [RING_LEN];
  logic signed [15:0] right_ring [RING_LEN];
  logic signed [15:0] sine_rom [SINE_LEN];
  logic [11:0] write_pos;
  logic [31:0] lfo_phase;
  longint left_fb, right_fb;

  logic [15:0] mix_wet, mod_depth, feedback_gain;
  logic [31:0] phase_step, right_offset;
  logic effect_mode;

  scf_pkg::out_word_t pending_words[$];
  int errors;
  int checked;

  function new();
    longint x, x2, p, s;
    int a, t;
    for (int k = 0; k < SINE_LEN; k++) begin
      a = (k * 65536) / SINE_LEN;
      t = a & 32767;
      if (t > 16384) t = 32768 - t;
      x  = t;
      x2 = (x * x) / 16384;
      p  = 2611;
      p  = -21167 + (p * x2) / 16384;
      p  = 51472 + (p * x2) / 16384;
      p  = (p * x) / 16384;
      if (p > 32767) p = 32767;
      s = ((a & 32768) != 0) ? -p : p;
      sine_rom[k] = 16'(s);
    end
    for (int i = 0; i < RING_LEN; i++) begin
      left_ring[i] = '0;
      right_ring[i] = '0;
    end
    write_pos = '0;
    lfo_phase = '0;
    left_fb = 0;
    right_fb = 0;
    mix_wet = scf_pkg::RST_MIX_WET;
    mod_depth = scf_pkg::RST_MOD_DEPTH;
    phase_step = scf_pkg::RST_PHASE_STEP;
    right_offset = scf_pkg::RST_RIGHT_OFFSET;
    feedback_gain = scf_pkg::RST_FEEDBACK;
    effect_mode = scf_pkg::RST_EFFECT_MODE;
    errors = 0;
    checked = 0;
  endfunction

  function void note_register(logic [scf_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    case (idx)
      scf_pkg::CFG_MIX_WET:      mix_wet = val[15:0];
      scf_pkg::CFG_MOD_DEPTH:    mod_depth = val[15:0];
      scf_pkg::CFG_PHASE_STEP:   phase_step = val;
      scf_pkg::CFG_RIGHT_OFFSET: right_offset = val;
      scf_pkg::CFG_FEEDBACK:     feedback_gain = val[15:0];
      scf_pkg::CFG_EFFECT_MODE:  effect_mode = val[0];
      default: ;
    endcase
  endfunction

  static function longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function longint tap_read(bit right_side, logic [31:0] phase);
    longint lfo, lo, span, dly, rd, f, r0, r1;
    int idx, i0, i1;
    idx = int'((64'(phase) * SINE_LEN) >> 32);
    lfo = (longint'(sine_rom[idx]) * longint'(mod_depth)) / 65536;
    lo   = effect_mode ? (RATE * 256) / 1000 : (RATE * 256) / 200;
    span = effect_mode ? (RATE * 256) / 250 : (RATE * 256) / 40;
    dly  = lo + (((lfo + 32768) * span) >>> 16);
    rd   = (longint'(write_pos) * 256 + RING_LEN * 256 - (dly % (RING_LEN * 256)))
           % (RING_LEN * 256);
    i0 = int'(rd >>> 8) % RING_LEN;
    i1 = (i0 + 1) % RING_LEN;
    f  = rd & 255;
    r0 = right_side ? right_ring[i0] : left_ring[i0];
    r1 = right_side ? right_ring[i1] : left_ring[i1];
    return (r0 * (256 - f) + r1 * f) / 256;
  endfunction

  function void note_sample(scf_pkg::in_word_t w);
    longint l, r, yl, yr;
    scf_pkg::out_word_t e;
    l = w.left_in;
    r = w.right_in;
    left_ring[write_pos]  = 16'(clip16(l + left_fb));
    right_ring[write_pos] = 16'(clip16(r + right_fb));
    yl = tap_read(1'b0, lfo_phase);
    yr = tap_read(1'b1, lfo_phase + right_offset);
    left_fb  = (yl * longint'(feedback_gain)) / 65536;
    right_fb = (yr * longint'(feedback_gain)) / 65536;
    lfo_phase = lfo_phase + phase_step;
    write_pos = write_pos + 1'b1;
    e.left_out  = 16'(clip16((l * (65536 - longint'(mix_wet)) + yl * longint'(mix_wet))
                             / 65536));
    e.right_out = 16'(clip16((r * (65536 - longint'(mix_wet)) + yr * longint'(mix_wet))
                             / 65536));
    pending_words.push_back(e);
  endfunction

  function void check_word(scf_pkg::out_word_t got);
    scf_pkg::out_word_t e;
    if (pending_words.size() == 0) begin
      $display("%0t: unexpected word, got %h", $time, got);
      errors++;
      return;
    end
    e = pending_words.pop_front();
    checked++;
    if (got.left_out !== e.left_out) begin
      $display("%0t: left_out mismatch, expected %0d, got %0d", $time, e.left_out,
               got.left_out);
      errors++;
    end
    if (got.right_out !== e.right_out) begin
      $display("%0t: right_out mismatch, expected %0d, got %0d", $time, e.right_out,
               got.right_out);
      errors++;
    end
  endfunction
endclass

module stereo_chorus_flanger_top_test;

  localparam longint CYCLE_LIMIT = 400000;

  logic clk, rst;
  logic in_valid, in_ready;
  scf_pkg::in_word_t in_data;
  logic out_valid, out_ready;
  scf_pkg::out_word_t out_data;
  logic cfg_valid, cfg_ready;
  logic [scf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [scf_pkg::CFG_DATA_W-1:0] cfg_data;

  sample_scoreboard board;
  longint cycles;
  int stall_mode;   // receiver back-pressure pattern selector
  int sent_words;

  stereo_chorus_flanger_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // output side: check on handshake, then pick next ready from the stall pattern
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) board.check_word(out_data);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= (cycles % 37) > 30;   // long stalls
        default: out_ready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  // one config write; the block is idle whenever this is called
  task automatic write_reg(input logic [scf_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.note_register(idx, val);
    @(posedge clk);
  endtask

  // one stereo word; gap cycles are inserted by the caller
  task automatic send_word(input scf_pkg::in_word_t w);
    in_data  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    board.note_sample(w);
    sent_words++;
  endtask

  task automatic pause_input(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // random words in bursts; loud inputs now and then to hit saturation
  // valid is dropped by the drain that follows
  task automatic random_words(input int count);
    int left_todo, burst;
    scf_pkg::in_word_t w;
    left_todo = count;
    while (left_todo > 0) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && left_todo > 0; i++) begin
        if ($urandom_range(0, 5) == 0) begin
          w.left_in  = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          w.right_in = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        end else begin
          w = $urandom;
        end
        send_word(w);
        left_todo--;
      end
      if ($urandom_range(0, 2) != 0) pause_input($urandom_range(1, 60));
    end
  endtask

  // wait until every word is back, then let the sequencer settle
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    scf_pkg::in_word_t w;
    board = new();
    rst = 1'b1;
    cycles = 0;
    sent_words = 0;
    stall_mode = 0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes at reset settings
    w = {16'sh7fff, 16'sh8000}; send_word(w);
    w = {16'sh8000, 16'sh7fff}; send_word(w);
    w = {16'sh0000, 16'shffff}; send_word(w);
    w = {16'sh0001, 16'sh0000}; send_word(w);
    w = {16'shaaaa, 16'sh5555}; send_word(w);
    w = {16'sh5555, 16'shaaaa}; send_word(w);
    // full scale words with feedback gain at its maximum
    drain();
    write_reg(scf_pkg::CFG_FEEDBACK, 32'd65535);
    write_reg(scf_pkg::CFG_MIX_WET, 32'd65535);
    write_reg(scf_pkg::CFG_PHASE_STEP, 32'hffff_ffff);  // phase wraps every word
    write_reg(scf_pkg::CFG_RIGHT_OFFSET, 32'h8000_0000);
    for (int i = 0; i < 8; i++) begin
      w = {16'sh7fff, 16'sh8000}; send_word(w);
    end
    drain();
    // flanger, zero depth, config index out of range, junk upper bits
    write_reg(scf_pkg::CFG_EFFECT_MODE, 32'hffff_fffe);
    write_reg(scf_pkg::CFG_EFFECT_MODE, 32'd1);
    write_reg(scf_pkg::CFG_MOD_DEPTH, 32'd0);
    write_reg(3'd6, 32'hdead_beef);
    write_reg(3'd7, 32'h1234_5678);
    write_reg(scf_pkg::CFG_MIX_WET, 32'hffff_0000);
    for (int i = 0; i < 5; i++) begin
      w = $urandom; send_word(w);
    end
    drain();

    // random phases across a spread of settings
    for (int ph = 0; ph < 8; ph++) begin
      stall_mode = ph % 4;
      write_reg(scf_pkg::CFG_MIX_WET, (ph == 1) ? 32'd0 : (ph == 2) ? 32'd65535 : $urandom);
      write_reg(scf_pkg::CFG_MOD_DEPTH, (ph == 3) ? 32'd65535 : (ph == 4) ? 32'd0 : $urandom);
      write_reg(scf_pkg::CFG_PHASE_STEP, (ph == 5) ? 32'hffff_ffff : (ph == 6) ? 32'd0 :
                $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4000000));
      write_reg(scf_pkg::CFG_RIGHT_OFFSET, (ph == 7) ? 32'hffff_ffff : $urandom);
      write_reg(scf_pkg::CFG_FEEDBACK, (ph == 2) ? 32'd64225 : (ph == 6) ? 32'd0 :
                $urandom_range(0, 65535));
      write_reg(scf_pkg::CFG_EFFECT_MODE, ph % 2);
      random_words(145);
      drain();
    end

    $display("covered %0d stereo words, %0d checked, chorus and flanger modes,",
             sent_words, board.checked);
    $display("register extremes, saturation and receiver stall patterns");
    if (board.errors == 0 && board.pending_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/scf_pkg.sv
rtl/scf_ram.sv
rtl/scf_ctrl.sv
rtl/scf_datapath.sv
rtl/stereo_chorus_flanger_top.sv
test/stereo_chorus_flanger_top_test.sv
